>>> hdl/prewitt_horizontal_edge_rgb_core_macros.svh
// assertion macros shared by the fifo and front rtl files
`ifndef PREWITT_HORIZONTAL_EDGE_RGB_CORE_MACROS_SVH
`define PREWITT_HORIZONTAL_EDGE_RGB_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define PHER_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pher assertion failed");

// next-cycle implication, disabled in reset
`define PHER_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pher assertion failed");

`else

`define PHER_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PHER_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/pher_pkg.sv
`timescale 1ns / 1ps

package pher_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int CFG_W         = 12;
    localparam int MIN_DIM       = 3;
    localparam int Q_DEPTH       = 4;
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

    // register indexes on the config port
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // floor(m / 3) == (m * 683) >> 11 for every m up to 765
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    // rgb pixel, red in the low byte
    typedef logic [23:0] t_pix;
    // one window column: {upper, middle, lower}
    typedef logic [71:0] t_col3;

    typedef struct packed {
        t_col3       left;
        t_col3       right;
        logic [11:0] row;
        logic [10:0] col;
        logic        last;
    } t_entry;

    typedef struct packed {
        logic [11:0] row;
        logic [10:0] col;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } t_result;

endpackage

>>> hdl/pher_ram.sv
`timescale 1ns / 1ps

module pher_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [W-1:0]  i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [W-1:0]  o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/pher_fifo.sv
`timescale 1ns / 1ps
`include "prewitt_horizontal_edge_rgb_core_macros.svh"

module pher_fifo #(
    parameter int W      = 8,
    parameter int DEPTH  = 4,
    localparam int AW    = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_data,
    input  logic             i_pop,
    output logic [W-1:0]     o_data,
    output logic             o_empty,
    output logic [CNT_W-1:0] o_count
);

    logic [W-1:0]     r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    `PHER_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_count == CNT_W'(DEPTH), !i_push)
    `PHER_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, r_count == '0, !i_pop)

endmodule

>>> hdl/pher_front.sv
`timescale 1ns / 1ps
`include "prewitt_horizontal_edge_rgb_core_macros.svh"

module pher_front #(
    parameter int MAX_WIDTH = pher_pkg::DEF_MAX_WIDTH,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [pher_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_push,
    input  pher_pkg::t_pix             i_px,
    output logic                       o_full,
    input  logic [pher_pkg::Q_CNT_W-1:0] i_q_count,
    output logic                       o_rd_en,
    output logic [CW-1:0]              o_rd_addr,
    input  pher_pkg::t_pix             i_up_rd,
    input  pher_pkg::t_pix             i_mid_rd,
    output logic                       o_wr_en,
    output logic [CW-1:0]              o_wr_addr,
    output pher_pkg::t_pix             o_up_wr,
    output pher_pkg::t_pix             o_mid_wr,
    output logic                       o_q_push,
    output pher_pkg::t_entry           o_q_entry
);

    import pher_pkg::*;

    localparam int WW = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1;
    localparam int CX = (CW > 11) ? CW : 11;
    localparam int QW = Q_CNT_W + 1;

    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [11:0]      r_row, n_row;
    logic [CW-1:0]    r_col, n_col;

    logic             r_s1_valid;
    t_pix             r_s1_px;
    logic [CW-1:0]    r_s1_addr;
    logic             r_s1_hit;
    logic [11:0]      r_s1_row;
    logic [10:0]      r_s1_col;
    logic             r_s1_last;

    t_col3            r_win0, r_win1;

    logic             acc;
    logic [WW-1:0]    cfg_w_x, eff_w, col_x, row_x, eff_h;
    logic [CX-1:0]    col_cx;
    logic             hit, last, wrap_col, wrap_row;

    always_comb begin
        cfg_w_x = WW'(r_cfg_w);
        if (cfg_w_x < WW'(MIN_DIM)) begin
            eff_w = WW'(MIN_DIM);
        end else if (cfg_w_x > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = cfg_w_x;
        end
        eff_h    = (r_cfg_h < CFG_W'(MIN_DIM)) ? WW'(MIN_DIM) : WW'(r_cfg_h);
        col_x    = WW'(r_col);
        row_x    = WW'(r_row);
        col_cx   = CX'(r_col) - CX'(1);
        hit      = (row_x >= WW'(2)) && (col_x >= WW'(2)) && (row_x < eff_h) && (col_x < eff_w);
        last     = (row_x == eff_h - WW'(1)) && (col_x == eff_w - WW'(1));
        wrap_col = (col_x + WW'(1)) >= eff_w;
        wrap_row = (row_x + WW'(1)) >= eff_h;
    end

    // one slot is kept for the word in the read stage
    assign o_full = (QW'(i_q_count) + QW'(r_s1_valid)) >= QW'(Q_DEPTH);
    assign acc    = i_push && !o_full;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (acc) begin
            if (wrap_col) begin
                n_col = '0;
                n_row = wrap_row ? 12'd0 : r_row + 12'd1;
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= RESET_WIDTH;
            r_cfg_h    <= RESET_HEIGHT;
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_win0     <= '0;
            r_win1     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                    default:          r_cfg_w <= r_cfg_w;
                endcase
            end
            r_row      <= n_row;
            r_col      <= n_col;
            r_s1_valid <= acc;
            if (r_s1_valid) begin
                r_win1 <= r_win0;
                r_win0 <= {i_up_rd, i_mid_rd, r_s1_px};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_px   <= i_px;
            r_s1_addr <= r_col;
            r_s1_hit  <= hit;
            r_s1_row  <= r_row - 12'd1;
            r_s1_col  <= col_cx[10:0];
            r_s1_last <= last;
        end
    end

    // line stores read on accept, rotated in the cycle after at the same column
    assign o_rd_en   = acc;
    assign o_rd_addr = r_col;
    assign o_wr_en   = r_s1_valid;
    assign o_wr_addr = r_s1_addr;
    assign o_up_wr   = i_mid_rd;
    assign o_mid_wr  = r_s1_px;

    assign o_q_push        = r_s1_valid && r_s1_hit;
    assign o_q_entry.left  = r_win1;
    assign o_q_entry.right = {i_up_rd, i_mid_rd, r_s1_px};
    assign o_q_entry.row   = r_s1_row;
    assign o_q_entry.col   = r_s1_col;
    assign o_q_entry.last  = r_s1_last;

    `PHER_ASSERT_NXT(a_store_write, i_clk, i_rst_n, acc, o_wr_en && (o_wr_addr == $past(r_col)))

endmodule

>>> hdl/pher_back.sv
`timescale 1ns / 1ps

module pher_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pher_pkg::t_entry             i_q_entry,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    input  logic [pher_pkg::Q_CNT_W-1:0] i_out_count,
    output logic                         o_res_push,
    output pher_pkg::t_result            o_res
);

    import pher_pkg::*;

    localparam int QW = Q_CNT_W + 1;

    logic             take;
    logic [9:0]       pos [3];
    logic [9:0]       neg [3];
    logic [9:0]       mag [3];
    logic [19:0]      prod [3];

    logic             r_a_valid;
    logic [9:0]       r_a_mag [3];
    logic [11:0]      r_a_row;
    logic [10:0]      r_a_col;
    logic             r_a_last;

    logic             r_b_valid;
    t_result          r_b;

    // credit check: words in flight must always fit the result queue
    assign take    = !i_q_empty &&
                     ((QW'(i_out_count) + QW'(r_a_valid) + QW'(r_b_valid)) < QW'(Q_DEPTH));
    assign o_q_pop = take;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pos[k] = 10'(i_q_entry.right[48 + 8*k +: 8]) + 10'(i_q_entry.right[24 + 8*k +: 8])
                   + 10'(i_q_entry.right[8*k +: 8]);
            neg[k] = 10'(i_q_entry.left[48 + 8*k +: 8]) + 10'(i_q_entry.left[24 + 8*k +: 8])
                   + 10'(i_q_entry.left[8*k +: 8]);
            mag[k] = (pos[k] >= neg[k]) ? pos[k] - neg[k] : neg[k] - pos[k];
            prod[k] = 20'(r_a_mag[k]) * 20'(DIV3_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= take;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int k = 0; k < 3; k++) begin
                r_a_mag[k] <= mag[k];
            end
            r_a_row  <= i_q_entry.row;
            r_a_col  <= i_q_entry.col;
            r_a_last <= i_q_entry.last;
        end
        if (r_a_valid) begin
            r_b.row   <= r_a_row;
            r_b.col   <= r_a_col;
            r_b.red   <= prod[0][DIV3_SHIFT +: 8];
            r_b.green <= prod[1][DIV3_SHIFT +: 8];
            r_b.blue  <= prod[2][DIV3_SHIFT +: 8];
            r_b.last  <= r_a_last;
        end
    end

    assign o_res_push = r_b_valid;
    assign o_res      = r_b;

endmodule

>>> hdl/prewitt_horizontal_edge_rgb_core.sv
`timescale 1ns / 1ps

// Horizontal Prewitt edge filter on an RGB raster stream. Pixels are pushed in
// raster order and one pixel is accepted every clock while full stays low; the
// line store read-modify-write and the queues are laid out so that a steady
// pixel-per-clock stream never stalls as long as results are popped as fast.
// Only interior pixels give a result, which appears once the pixel below-right
// of the center is accepted and has passed the line store read, queue, gradient
// stage, divide-by-three stage and result queue, or later while the result
// queue backs up. Two line stores of MAX_WIDTH x 24 bit sit in simple dual-port
// RAM and need no clearing after reset. image_width and image_height are to be
// written by the user through the config port only while the stream is idle;
// the block does not check it. The position counters wrap after the last pixel.
module prewitt_horizontal_edge_rgb_core #(
    parameter int MAX_WIDTH = pher_pkg::DEF_MAX_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [pher_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_red_in,
    input  logic [7:0]                 i_green_in,
    input  logic [7:0]                 i_blue_in,
    output logic                       empty,
    input  logic                       pop,
    output logic [11:0]                o_center_row,
    output logic [10:0]                o_center_col,
    output logic [7:0]                 o_edge_red,
    output logic [7:0]                 o_edge_green,
    output logic [7:0]                 o_edge_blue,
    output logic                       o_frame_last
);

    import pher_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic               rd_en, wr_en;
    logic [CW-1:0]      rd_addr, wr_addr;
    t_pix               up_rd, mid_rd, up_wr, mid_wr;

    logic               q_push, q_pop, q_empty;
    t_entry             q_in, q_out;
    logic [Q_CNT_W-1:0] q_count;

    logic               res_push, res_pop;
    t_result            res_in, res_out;
    logic [Q_CNT_W-1:0] res_count;

    pher_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_px       ({i_blue_in, i_green_in, i_red_in}),
        .o_full     (full),
        .i_q_count  (q_count),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_up_rd    (up_rd),
        .i_mid_rd   (mid_rd),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_up_wr    (up_wr),
        .o_mid_wr   (mid_wr),
        .o_q_push   (q_push),
        .o_q_entry  (q_in)
    );

    pher_ram #(
        .W     ($bits(t_pix)),
        .DEPTH (MAX_WIDTH)
    ) u_store_upper (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (up_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (up_rd)
    );

    pher_ram #(
        .W     ($bits(t_pix)),
        .DEPTH (MAX_WIDTH)
    ) u_store_middle (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (mid_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (mid_rd)
    );

    pher_fifo #(
        .W     ($bits(t_entry)),
        .DEPTH (Q_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    pher_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_entry   (q_out),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_out_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    assign res_pop = pop && !empty;

    pher_fifo #(
        .W     ($bits(t_result)),
        .DEPTH (Q_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (res_pop),
        .o_data  (res_out),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_center_row = res_out.row;
    assign o_center_col = res_out.col;
    assign o_edge_red   = res_out.red;
    assign o_edge_green = res_out.green;
    assign o_edge_blue  = res_out.blue;
    assign o_frame_last = res_out.last;

endmodule

>>> bench/prewitt_edge_checker.sv
`timescale 1ns / 1ps

module prewitt_edge_checker #(
    parameter int MAX_WIDTH = pher_pkg::DEF_MAX_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [pher_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_push,
    input  logic                       i_full,
    input  logic [7:0]                 i_red,
    input  logic [7:0]                 i_green,
    input  logic [7:0]                 i_blue,
    input  logic                       i_empty,
    input  logic                       i_pop,
    input  logic [11:0]                i_center_row,
    input  logic [10:0]                i_center_col,
    input  logic [7:0]                 i_edge_red,
    input  logic [7:0]                 i_edge_green,
    input  logic [7:0]                 i_edge_blue,
    input  logic                       i_frame_last,
    output int                         o_fails,
    output int                         o_pending
);

    pher_pkg::t_pix    upper_line [MAX_WIDTH];
    pher_pkg::t_pix    middle_line [MAX_WIDTH];
    // {upper, middle, lower} of the previous column and the one before it
    pher_pkg::t_pix    near_col [3];
    pher_pkg::t_pix    far_col [3];
    pher_pkg::t_result pending_edges [$];
    logic [pher_pkg::CFG_W-1:0] width_reg;
    logic [pher_pkg::CFG_W-1:0] height_reg;
    int row_pos;
    int col_pos;

    task automatic report_mismatch(input string what);
        o_fails++;
        if (o_fails <= 50) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    task automatic filter_pixel(input pher_pkg::t_pix px);
        pher_pkg::t_pix    up;
        pher_pkg::t_pix    mid;
        pher_pkg::t_result want;
        logic [7:0]        grad [3];
        int ew;
        int eh;
        int plus;
        int minus;
        int diff;
        int k;
        ew = (width_reg < pher_pkg::MIN_DIM) ? pher_pkg::MIN_DIM :
             (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        eh = (height_reg < pher_pkg::MIN_DIM) ? pher_pkg::MIN_DIM : height_reg;
        up = upper_line[col_pos];
        mid = middle_line[col_pos];
        if (row_pos >= 2 && col_pos >= 2 && row_pos < eh && col_pos < ew) begin
            for (k = 0; k < 3; k++) begin
                plus = up[8*k +: 8] + mid[8*k +: 8] + px[8*k +: 8];
                minus = far_col[0][8*k +: 8] + far_col[1][8*k +: 8] + far_col[2][8*k +: 8];
                diff = (plus >= minus) ? plus - minus : minus - plus;
                grad[k] = 8'(diff / 3);
            end
            want.row = 12'(row_pos - 1);
            want.col = 11'(col_pos - 1);
            want.red = grad[0];
            want.green = grad[1];
            want.blue = grad[2];
            want.last = (row_pos == eh - 1 && col_pos == ew - 1);
            pending_edges.push_back(want);
        end
        far_col = near_col;
        near_col[0] = up;
        near_col[1] = mid;
        near_col[2] = px;
        upper_line[col_pos] = mid;
        middle_line[col_pos] = px;
        // a column beyond a shrunk width wraps at the next pixel, a row beyond one at the next column wrap
        if (col_pos + 1 >= ew) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= eh) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    task automatic check_edge();
        pher_pkg::t_result want;
        if (pending_edges.size() == 0) begin
            report_mismatch($sformatf("unexpected word for row %0d col %0d",
                                      i_center_row, i_center_col));
            return;
        end
        want = pending_edges.pop_front();
        if (i_center_row !== want.row)
            report_mismatch($sformatf("center_row %0d, want %0d", i_center_row, want.row));
        if (i_center_col !== want.col)
            report_mismatch($sformatf("center_col %0d, want %0d", i_center_col, want.col));
        if (i_edge_red !== want.red)
            report_mismatch($sformatf("edge_red %0d, want %0d at (%0d,%0d)",
                                      i_edge_red, want.red, want.row, want.col));
        if (i_edge_green !== want.green)
            report_mismatch($sformatf("edge_green %0d, want %0d at (%0d,%0d)",
                                      i_edge_green, want.green, want.row, want.col));
        if (i_edge_blue !== want.blue)
            report_mismatch($sformatf("edge_blue %0d, want %0d at (%0d,%0d)",
                                      i_edge_blue, want.blue, want.row, want.col));
        if (i_frame_last !== want.last)
            report_mismatch($sformatf("frame_last %0b, want %0b at (%0d,%0d)",
                                      i_frame_last, want.last, want.row, want.col));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg = pher_pkg::RESET_WIDTH;
            height_reg = pher_pkg::RESET_HEIGHT;
            row_pos = 0;
            col_pos = 0;
            near_col = '{default: '0};
            far_col = '{default: '0};
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == pher_pkg::CFG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_data;
                end else begin
                    height_reg = i_cfg_data;
                end
            end
            if (i_push && !i_full) begin
                filter_pixel({i_blue, i_green, i_red});
            end
            if (i_pop && !i_empty) begin
                check_edge();
            end
        end
        o_pending = pending_edges.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 300;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic                       cfg_idx = pher_pkg::CFG_IMAGE_WIDTH;
    logic [pher_pkg::CFG_W-1:0] cfg_data = '0;
    logic                       push = 1'b0;
    logic                       full;
    logic [7:0]                 red = '0;
    logic [7:0]                 green = '0;
    logic [7:0]                 blue = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [11:0]                center_row;
    logic [10:0]                center_col;
    logic [7:0]                 edge_red;
    logic [7:0]                 edge_green;
    logic [7:0]                 edge_blue;
    logic                       frame_last;

    int fails;
    int pending;
    int send_idle_pct = 17;
    int recv_idle_pct = 85;
    int idle_cycles = 0;
    // raster position and raw register values as the stream sees them
    int cur_w = pher_pkg::RESET_WIDTH;
    int cur_h = pher_pkg::RESET_HEIGHT;
    int at_col = 0;
    int at_row = 0;

    prewitt_horizontal_edge_rgb_core DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .push         (push),
        .full         (full),
        .i_red_in     (red),
        .i_green_in   (green),
        .i_blue_in    (blue),
        .empty        (empty),
        .pop          (pop),
        .o_center_row (center_row),
        .o_center_col (center_col),
        .o_edge_red   (edge_red),
        .o_edge_green (edge_green),
        .o_edge_blue  (edge_blue),
        .o_frame_last (frame_last)
    );

    prewitt_edge_checker edge_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_red        (red),
        .i_green      (green),
        .i_blue       (blue),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_center_row (center_row),
        .i_center_col (center_col),
        .i_edge_red   (edge_red),
        .i_edge_green (edge_green),
        .i_edge_blue  (edge_blue),
        .i_frame_last (frame_last),
        .o_fails      (fails),
        .o_pending    (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int clamp_width(input int v);
        return (v < pher_pkg::MIN_DIM) ? pher_pkg::MIN_DIM :
               (v > pher_pkg::DEF_MAX_WIDTH) ? pher_pkg::DEF_MAX_WIDTH : v;
    endfunction

    function automatic int clamp_height(input int v);
        return (v < pher_pkg::MIN_DIM) ? pher_pkg::MIN_DIM : v;
    endfunction

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        do @(posedge clk); while (full);
        at_col++;
        if (at_col >= clamp_width(cur_w)) begin
            at_col = 0;
            at_row++;
            if (at_row >= clamp_height(cur_h)) at_row = 0;
        end
    endtask

    task automatic send_random_pixel();
        send_pixel(pick_sample(), pick_sample(), pick_sample());
    endtask

    // lets every expected word drain, plus any pixel still in the pipe
    task automatic wait_idle();
        push <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int w, input int h);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_idx <= pher_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= w[11:0];
        @(posedge clk);
        cfg_idx <= pher_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= h[11:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    task automatic finish_frame();
        while (at_col != 0 || at_row != 0) send_random_pixel();
    endtask

    task automatic random_traffic(input int budget);
        int sent;
        int w;
        int h;
        int n;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(9))
                0: w = $urandom_range(2);
                1: w = $urandom_range(16, 9);
                default: w = $urandom_range(8, 3);
            endcase
            h = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
            // line stores only hold columns already visited, so grow only at frame start
            if (clamp_width(w) > clamp_width(cur_w) && (at_col != 0 || at_row != 0)) begin
                w = cur_w;
            end
            configure(w, h);
            if ($urandom_range(9) < 7 && at_row < clamp_height(h) && at_col < clamp_width(w)) begin
                n = (clamp_height(h) - at_row) * clamp_width(w) - at_col;
            end else begin
                n = $urandom_range(12, 1);
            end
            repeat (n) send_random_pixel();
            sent += n;
        end
    endtask

    initial begin : stimulus
        int row;
        int col;
        logic [7:0] g;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset size: part of the first row
        repeat (24) send_random_pixel();

        // shrink mid-frame: the next pixel lies beyond the new size
        configure(3, 3);
        send_random_pixel();
        finish_frame();

        // height below range, full-scale and truncated gradients
        configure(4, 1);
        for (row = 0; row < 3; row++) begin
            for (col = 0; col < 4; col++) begin
                g = (col == 0) ? 8'd255 : (col == 1) ? 8'd1 : (col == 3) ? 8'd254 :
                    (row == 2) ? 8'd1 : 8'd0;
                send_pixel((col == 1 || col == 2) ? 8'd255 : 8'd0, g,
                           (row == 2 && col == 3) ? 8'd9 : 8'd7);
            end
        end

        // width below range
        configure(2, 4);
        repeat (12) send_random_pixel();

        random_traffic(RANDOM_ITEMS / 3);

        send_idle_pct = 85;
        recv_idle_pct = 17;
        random_traffic(RANDOM_ITEMS / 3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(RANDOM_ITEMS / 3);

        // width above range, then the tallest frame entered mid-frame
        finish_frame();
        configure(4095, 3);
        repeat (16) send_random_pixel();
        configure(3, 4095);
        repeat (3 * 9) send_random_pixel();

        wait_idle();
        if (fails == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
